@@ hw/rtl/nmeasc_pkg.sv @@
// Shared types and constants for the NMEA sentence checker.
package nmeasc_pkg;

	localparam int CNT_WIDTH_DEF = 32;
	localparam int LEN_W         = 10;
	localparam int MIN_W         = 8;
	localparam int IDX_W         = 4;
	localparam int CFG_DATA_W    = 10;
	localparam int CFG_SEL_W     = 2;

	// Configuration register indexes
	localparam logic [CFG_SEL_W-1:0] CFG_MAX_LEN = 2'd0;
	localparam logic [CFG_SEL_W-1:0] CFG_MIN_LEN = 2'd1;
	localparam logic [CFG_SEL_W-1:0] CFG_SAT_IDX = 2'd2;

	localparam logic [LEN_W-1:0] MAX_LEN_RST = 10'd256;
	localparam logic [MIN_W-1:0] MIN_LEN_RST = 8'd10;
	localparam logic [IDX_W-1:0] SAT_IDX_RST = 4'd7;

	typedef struct packed {
		logic [LEN_W-1:0] max_len;
		logic [MIN_W-1:0] min_len;
		logic [IDX_W-1:0] sat_idx;
	} cfg_t;

	// Line summary from the parser at the byte that closes a line
	typedef struct packed {
		logic             emit;
		logic             valid;
		logic [7:0]       sats;
		logic             is_gga;
		logic [LEN_W-1:0] len;
	} line_end_t;

	typedef struct packed {
		logic             line_valid;
		logic [7:0]       satellites;
		logic             is_gga;
		logic [LEN_W-1:0] line_length;
		logic [31:0]      valid_count;
		logic [31:0]      byte_count;
		logic             fix_seen;
	} result_t;

endpackage

@@ hw/rtl/nmeasc_rx_if.sv @@
// Byte request channel into the checker.
interface nmeasc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/nmeasc_res_if.sv @@
// Line result channel out of the checker.
interface nmeasc_res_if;
	logic        valid;
	logic        ready;
	logic        line_valid;
	logic [7:0]  satellites;
	logic        is_gga;
	logic [9:0]  line_length;
	logic [31:0] valid_count;
	logic [31:0] byte_count;
	logic        fix_seen;

	modport source (output valid, output line_valid, output satellites, output is_gga,
		output line_length, output valid_count, output byte_count, output fix_seen,
		input ready);
	modport sink (input valid, input line_valid, input satellites, input is_gga,
		input line_length, input valid_count, input byte_count, input fix_seen,
		output ready);
endinterface

@@ hw/rtl/nmea_sentence_checker.sv @@
// Top level of the NMEA sentence checker.
// Usage:
//  rx  : one raw UART byte per request (valid/ready). Printable bytes build
//        the current line, CR or LF closes it, anything else is only counted.
//  res : one request per closed non-empty line: validity (leading '$', a '*',
//        XOR checksum match, minimum length), GGA flag, satellite count, line
//        length, running valid-line and byte counters, sticky fix flag.
//  cfg : write-only register port (cfg_we/cfg_index/cfg_data); write it only
//        while no line result is pending.
// Throughput: one byte per cycle while rx.ready is high. The parser state
//  updates in the cycle a byte is taken; the result for the closing CR/LF
//  is registered into the result register, or into the skid entry when that is full.
// Stall: a two-entry output buffer (result register plus skid) sits before
//  res; rx.ready drops only when both are full, i.e. two results are waiting.
// Reset (arst_n low): line state, counters and fix flag clear, config
//  registers return to 256 / 10 / 7, output buffer empties.
// Counters are COUNTER_WIDTH bits, saturating; res carries the low 32 bits.
module nmea_sentence_checker import nmeasc_pkg::*; #(
	parameter int COUNTER_WIDTH = CNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_SEL_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	nmeasc_rx_if.sink             rx,
	nmeasc_res_if.source          res
);

	cfg_t      cfg_q;
	line_end_t line_end;
	logic      take;

	logic [COUNTER_WIDTH-1:0] byte_cnt_q, byte_nxt;
	logic [COUNTER_WIDTH-1:0] valid_cnt_q, valid_nxt;
	logic [COUNTER_WIDTH+31:0] byte_ext, valid_ext;
	logic                      fix_q, fix_nxt;
	logic                      good_line;

	result_t main_q, skid_q, res_new;
	logic    main_v_q, skid_v_q;
	logic    push, pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len <= MAX_LEN_RST;
			cfg_q.min_len <= MIN_LEN_RST;
			cfg_q.sat_idx <= SAT_IDX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_LEN: cfg_q.max_len <= cfg_data[LEN_W-1:0];
				CFG_MIN_LEN: cfg_q.min_len <= cfg_data[MIN_W-1:0];
				CFG_SAT_IDX: cfg_q.sat_idx <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	assign rx.ready = !skid_v_q;
	assign take     = rx.valid && rx.ready;

	nmeasc_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.rx_byte  (rx.rx_byte),
		.cfg      (cfg_q),
		.line_end (line_end)
	);

	// Counters and fix flag; the result carries the values after this byte
	assign good_line = line_end.emit && line_end.valid;
	assign byte_nxt  = (&byte_cnt_q) ? byte_cnt_q : byte_cnt_q + COUNTER_WIDTH'(1);
	assign valid_nxt = (good_line && !(&valid_cnt_q)) ? valid_cnt_q + COUNTER_WIDTH'(1)
		: valid_cnt_q;
	assign fix_nxt   = fix_q || (good_line && line_end.sats != 8'd0);
	assign byte_ext  = {32'd0, byte_nxt};
	assign valid_ext = {32'd0, valid_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			valid_cnt_q <= '0;
			fix_q       <= 1'b0;
		end else if (take) begin
			byte_cnt_q  <= byte_nxt;
			valid_cnt_q <= valid_nxt;
			fix_q       <= fix_nxt;
		end
	end

	always_comb begin
		res_new.line_valid  = line_end.valid;
		res_new.satellites  = line_end.sats;
		res_new.is_gga      = line_end.is_gga;
		res_new.line_length = line_end.len;
		res_new.valid_count = valid_ext[31:0];
		res_new.byte_count  = byte_ext[31:0];
		res_new.fix_seen    = fix_nxt;
	end

	// Output buffer: result register plus skid entry
	assign push = take && line_end.emit;
	assign pop  = main_v_q && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) skid_v_q <= 1'b0;
		end else if (push) begin
			if (main_v_q && !pop) skid_v_q <= 1'b1;
			else main_v_q <= 1'b1;
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) main_q <= skid_q;
		end else if (push) begin
			if (main_v_q && !pop) skid_q <= res_new;
			else main_q <= res_new;
		end
	end

	assign res.valid       = main_v_q;
	assign res.line_valid  = main_q.line_valid;
	assign res.satellites  = main_q.satellites;
	assign res.is_gga      = main_q.is_gga;
	assign res.line_length = main_q.line_length;
	assign res.valid_count = main_q.valid_count;
	assign res.byte_count  = main_q.byte_count;
	assign res.fix_seen    = main_q.fix_seen;

	// Skid entry is only ever filled behind a full result register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry valid with empty result register");

	// Fix flag is sticky
	a_fix_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fix_q |=> fix_q)
		else $error("fix flag cleared");

	// A valid line always has a nonzero length and a nonzero valid count
	a_valid_line: assert property (@(posedge clk) disable iff (!arst_n)
		(main_v_q && main_q.line_valid) |->
		(main_q.valid_count != 32'd0 && main_q.line_length != '0))
		else $error("valid line with zero count or length");

endmodule

@@ hw/rtl/nmeasc_parse.sv @@
// Per-line parser: framing, checksum, GGA detection and satellite field.
module nmeasc_parse import nmeasc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output line_end_t  line_end
);

	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_TILDE  = 8'd126;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [15:0] CH_GG    = 16'h4747;
	localparam logic [IDX_W-1:0] COMMA_MAX = '1;

	// {ok, nibble}
	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			return {1'b1, t[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	logic [LEN_W-1:0] len_q, len_d;
	logic             dollar_q, dollar_d;
	logic             star_q, star_d;
	logic [7:0]       xor_q, xor_d;
	logic [1:0]       hex_cnt_q, hex_cnt_d;
	logic             hex_stop_q, hex_stop_d;
	logic [7:0]       sum_q, sum_d;
	logic [15:0]      last2_q, last2_d;
	logic             gga_q, gga_d;
	logic [IDX_W-1:0] comma_q, comma_d;
	logic [7:0]       sat_q, sat_d;
	logic             sat_stop_q, sat_stop_d;
	logic             sat_any_q, sat_any_d;

	logic       is_eol, printable, is_digit;
	logic [4:0] hx;
	logic [7:0] dig;
	logic [7:0] sat_mul;

	assign is_eol    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
	assign printable = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
	assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign hx        = hex_dec(rx_byte);
	assign dig       = rx_byte - CH_ZERO;
	assign sat_mul   = {sat_q[4:0], 3'b000} + {sat_q[6:0], 1'b0} + {4'b0000, dig[3:0]};

	always_comb begin
		line_end.emit   = is_eol && (len_q != '0);
		line_end.valid  = (len_q >= {2'b00, cfg.min_len}) && dollar_q && star_q
			&& (xor_q == sum_q);
		line_end.sats   = (gga_q && comma_q > cfg.sat_idx && sat_any_q) ? sat_q : 8'd0;
		line_end.is_gga = gga_q;
		line_end.len    = len_q;
	end

	always_comb begin
		len_d      = len_q;
		dollar_d   = dollar_q;
		star_d     = star_q;
		xor_d      = xor_q;
		hex_cnt_d  = hex_cnt_q;
		hex_stop_d = hex_stop_q;
		sum_d      = sum_q;
		last2_d    = last2_q;
		gga_d      = gga_q;
		comma_d    = comma_q;
		sat_d      = sat_q;
		sat_stop_d = sat_stop_q;
		sat_any_d  = sat_any_q;
		// len + 1 > max  <=>  len >= max
		if (is_eol || (printable && len_q >= cfg.max_len)) begin
			len_d      = '0;
			dollar_d   = 1'b0;
			star_d     = 1'b0;
			xor_d      = '0;
			hex_cnt_d  = '0;
			hex_stop_d = 1'b0;
			sum_d      = '0;
			last2_d    = '0;
			gga_d      = 1'b0;
			comma_d    = '0;
			sat_d      = '0;
			sat_stop_d = 1'b0;
			sat_any_d  = 1'b0;
		end else if (printable) begin
			if (len_q == '0) begin
				dollar_d = (rx_byte == CH_DOLLAR);
				star_d   = (rx_byte == CH_STAR);
			end else if (!star_q) begin
				if (rx_byte == CH_STAR) star_d = 1'b1;
				else xor_d = xor_q ^ rx_byte;
			end else if (!hex_stop_q && hex_cnt_q != 2'd2) begin
				if (!hx[4]) begin
					hex_stop_d = 1'b1;
				end else begin
					sum_d     = {sum_q[3:0], hx[3:0]};
					hex_cnt_d = hex_cnt_q + 2'd1;
				end
			end
			if (rx_byte == CH_A && last2_q == CH_GG) gga_d = 1'b1;
			last2_d = {last2_q[7:0], rx_byte};
			if (rx_byte == CH_COMMA) begin
				if (comma_q != COMMA_MAX) comma_d = comma_q + IDX_W'(1);
			end else if (comma_q == cfg.sat_idx) begin
				sat_any_d = 1'b1;
				if (!sat_stop_q && is_digit) sat_d = sat_mul;
				else sat_stop_d = 1'b1;
			end
			len_d = len_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			dollar_q   <= 1'b0;
			star_q     <= 1'b0;
			xor_q      <= '0;
			hex_cnt_q  <= '0;
			hex_stop_q <= 1'b0;
			sum_q      <= '0;
			last2_q    <= '0;
			gga_q      <= 1'b0;
			comma_q    <= '0;
			sat_q      <= '0;
			sat_stop_q <= 1'b0;
			sat_any_q  <= 1'b0;
		end else if (take) begin
			len_q      <= len_d;
			dollar_q   <= dollar_d;
			star_q     <= star_d;
			xor_q      <= xor_d;
			hex_cnt_q  <= hex_cnt_d;
			hex_stop_q <= hex_stop_d;
			sum_q      <= sum_d;
			last2_q    <= last2_d;
			gga_q      <= gga_d;
			comma_q    <= comma_d;
			sat_q      <= sat_d;
			sat_stop_q <= sat_stop_d;
			sat_any_q  <= sat_any_d;
		end
	end

endmodule

@@ verif/tb.sv @@
// Self-checking bench for nmea_sentence_checker: byte requests in, line result requests out.
`timescale 1ns / 1ps

module tb;
	import nmeasc_pkg::*;

	localparam logic [7:0] CR = 8'd13;
	localparam logic [7:0] LF = 8'd10;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_SEL_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	nmeasc_rx_if  rx_bus();
	nmeasc_res_if res_bus();

	nmea_sentence_checker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_bus),
		.res       (res_bus)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the checker: configuration, per-line parse state and
	// the running totals. Initial values are the post-reset values.
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] cfg_max_len = MAX_LEN_RST;
	logic [MIN_W-1:0] cfg_min_len = MIN_LEN_RST;
	logic [IDX_W-1:0] cfg_sat_idx = SAT_IDX_RST;

	logic [LEN_W-1:0] cur_len     = '0;
	bit               lead_dollar = 1'b0;
	bit               star_found  = 1'b0;
	logic [7:0]       body_xor    = '0;
	logic [1:0]       hex_cnt     = '0;
	bit               hex_done    = 1'b0;
	logic [7:0]       sum_field   = '0;
	logic [15:0]      prev_pair   = '0;
	bit               gga_hit     = 1'b0;
	logic [3:0]       commas      = '0;
	logic [7:0]       sat_acc     = '0;
	bit               sat_done    = 1'b0;
	logic [9:0]       sat_chars   = '0;
	logic [31:0]      valid_lines = '0;
	logic [31:0]      bytes_seen  = '0;
	bit               fix_latched = 1'b0;

	result_t     line_results_q[$];   // results still owed by the DUT
	logic [7:0]  pending_bytes[$];    // stimulus not yet offered
	int          pushed_total = 0;
	int          mismatch_cnt = 0;
	result_t     got_want;

	// handshake / idling state
	bit rx_taken  = 1'b0;
	int rx_gap    = 0;
	int res_stall = 0;
	bit rx_calm   = 1'b0;
	bit res_calm  = 1'b1;

	function automatic void clear_line_state();
		cur_len     = '0;
		lead_dollar = 1'b0;
		star_found  = 1'b0;
		body_xor    = '0;
		hex_cnt     = '0;
		hex_done    = 1'b0;
		sum_field   = '0;
		prev_pair   = '0;
		gga_hit     = 1'b0;
		commas      = '0;
		sat_acc     = '0;
		sat_done    = 1'b0;
		sat_chars   = '0;
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	// Advance the shadow parser by one accepted byte; a CR/LF that closes a
	// non-empty line queues the line result the DUT owes us.
	function automatic void predict_byte(logic [7:0] c);
		result_t r;
		bit      ok;
		bit      closed;
		int      h;
		if (bytes_seen != '1) bytes_seen++;
		if (c == LF || c == CR) begin
			if (cur_len == 0) return;   // blank line: nothing owed
			ok = cur_len >= cfg_min_len && lead_dollar && star_found && body_xor == sum_field;
			// satellite field must be terminated by the following comma
			closed = commas > cfg_sat_idx && sat_chars != 0;
			r.satellites = (gga_hit && closed) ? sat_acc : 8'd0;
			if (ok) begin
				if (valid_lines != '1) valid_lines++;
				if (r.satellites != 0) fix_latched = 1'b1;
			end
			r.line_valid  = ok;
			r.is_gga      = gga_hit;
			r.line_length = cur_len;
			r.valid_count = valid_lines;
			r.byte_count  = bytes_seen;
			r.fix_seen    = fix_latched;
			line_results_q.push_back(r);
			clear_line_state();
		end else if (c >= 8'd32 && c <= 8'd126) begin
			if ({1'b0, cur_len} + 11'd1 > {1'b0, cfg_max_len}) begin
				// too long: drop the whole line, this byte included
				clear_line_state();
			end else begin
				if (cur_len == 0) begin
					lead_dollar = (c == "$");
					if (c == "*") star_found = 1'b1;   // a leading star still counts
				end else if (!star_found) begin
					if (c == "*") star_found = 1'b1;
					else body_xor ^= c;
				end else if (!hex_done && hex_cnt < 2) begin
					h = hex_digit(c);
					if (h < 0) hex_done = 1'b1;
					else begin
						sum_field = {sum_field[3:0], 4'(h)};
						hex_cnt++;
					end
				end
				if (c == "A" && prev_pair == "GG") gga_hit = 1'b1;
				prev_pair = {prev_pair[7:0], c};
				if (c == ",") begin
					if (commas != 4'd15) commas++;
				end else if (commas == cfg_sat_idx) begin
					if (sat_chars != 10'd1023) sat_chars++;
					// only leading decimal digits build the count, modulo 256
					if (!sat_done && c >= "0" && c <= "9") sat_acc = sat_acc * 8'd10 + (c - "0");
					else sat_done = 1'b1;
				end
				cur_len++;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void push_byte(logic [7:0] b);
		pending_bytes.push_back(b);
		pushed_total++;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endfunction

	function automatic void push_line(string s, logic [7:0] term);
		push_text(s);
		push_byte(term);
	endfunction

	// CR and LF in every order; a second terminator is a blank line
	function automatic void push_line_end();
		case ($urandom_range(0, 3))
			0: begin push_byte(CR); push_byte(LF); end
			1: push_byte(CR);
			2: push_byte(LF);
			default: begin push_byte(LF); push_byte(CR); end
		endcase
	endfunction

	// plain: any printable but the field and checksum separators;
	// otherwise biased toward the characters the parser reacts to
	function automatic logic [7:0] rand_char(bit plain);
		string      hot = "$*,GA0123456789";
		logic [7:0] c;
		if (!plain && $urandom_range(0, 1) == 1) return hot[$urandom_range(0, hot.len() - 1)];
		do c = 8'($urandom_range(32, 126)); while (plain && (c == "," || c == "*"));
		return c;
	endfunction

	function automatic void push_filler(int n);
		repeat (n) push_byte(rand_char(1'b0));
	endfunction

	function automatic logic [7:0] xor_of(string s);
		logic [7:0] x = '0;
		for (int i = 0; i < s.len(); i++) x ^= s[i];
		return x;
	endfunction

	// One NMEA-shaped sentence without its terminator, mostly well formed.
	function automatic string make_sentence();
		string      body;
		string      f;
		string      s;
		string      signs = "- +";
		int         nf;
		int         r;
		logic [7:0] sum;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: body = "GPGGA";
			4, 5:       body = "GNGGA";
			6:          body = "GPRMC";
			7:          body = "GPGSV";
			default:    body = $sformatf("%c%c%c%c%c", 8'($urandom_range(65, 90)),
				8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
				8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)));
		endcase
		nf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 15);
		for (int k = 0; k < nf; k++) begin
			f = "";
			r = $urandom_range(0, 9);
			if (r >= 1 && r <= 6) begin
				// long digit runs push the count past 255
				repeat ((r == 6) ? $urandom_range(4, 6) : $urandom_range(1, 3))
					f = $sformatf("%s%0d", f, $urandom_range(0, 9));
			end else if (r == 7) begin
				f = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
			end else if (r == 8) begin
				f = $sformatf("%c%0d", signs[$urandom_range(0, 2)], $urandom_range(0, 20));
			end else if (r == 9) begin
				repeat ($urandom_range(1, 3)) f = $sformatf("%s%c", f, rand_char(1'b1));
			end
			body = {body, ",", f};
		end
		sum = xor_of(body);
		case ($urandom_range(0, 19))
			0: s = {"$", body};                                       // no star at all
			1: s = {"$", body, "*"};                                  // star, no digits
			2: s = $sformatf("$%s*%0X", body, sum[3:0]);              // single digit
			3: s = $sformatf("$%s*%02X", body, sum ^ 8'($urandom_range(1, 255)));
			4: s = $sformatf("$%s*%02X%0X", body, sum, $urandom_range(0, 15));
			5: s = $sformatf("$%s*%0Xz", body, sum[7:4]);             // digit then junk
			default: s = ($urandom_range(0, 1) == 1) ? $sformatf("$%s*%02X", body, sum)
				: $sformatf("$%s*%02x", body, sum);
		endcase
		if ($urandom_range(0, 19) == 0) s[0] = "!";
		return s;
	endfunction

	// Random traffic: mostly sentences, with short junk lines, raw noise
	// bytes, lines at or past the length limit and blank lines mixed in.
	function automatic void random_lines(int budget);
		int stop_at = pushed_total + budget;
		int kind;
		while (pushed_total < stop_at) begin
			kind = $urandom_range(0, 19);
			if (kind < 12) begin
				push_text(make_sentence());
				push_line_end();
			end else if (kind < 15) begin
				push_filler($urandom_range(1, 20));
				push_line_end();
			end else if (kind < 17) begin
				repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
			end else if (kind < 19 && cfg_max_len <= 10'd130) begin
				push_filler(cfg_max_len + $urandom_range(0, 3));
				push_line_end();
			end else begin
				push_line_end();
			end
		end
	endfunction

	function automatic int pick_gap();
		int r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 93) return $urandom_range(3, 6);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(string name, longint unsigned want,
		longint unsigned got);
		if (want != got) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Config writes happen only with the pipe drained; upper data bits
	// beyond each register's width carry junk that must be ignored.
	task automatic apply_setting(logic [LEN_W-1:0] max_len, logic [MIN_W-1:0] min_len,
		logic [IDX_W-1:0] sat_idx);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_LEN;
		cfg_data  <= max_len;
		@(negedge clk);
		cfg_index <= CFG_MIN_LEN;
		cfg_data  <= {2'($urandom), min_len};
		@(negedge clk);
		cfg_index <= CFG_SAT_IDX;
		cfg_data  <= {6'($urandom), sat_idx};
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_max_len = max_len;
		cfg_min_len = min_len;
		cfg_sat_idx = sat_idx;
	endtask

	// Sender holds off until every queued byte went in and every owed
	// result came out.
	task automatic wait_quiet();
		while (pending_bytes.size() != 0 || rx_bus.valid) @(posedge clk);
		while (line_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Byte driver: launches at the falling edge, holds a request until it
	// is taken, then optionally idles before the next one.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_bus.valid && !rx_taken) begin
				// request still waiting for ready
			end else if (rx_gap != 0) begin
				rx_bus.valid <= 1'b0;
				rx_gap       <= rx_gap - 1;
			end else if (pending_bytes.size() != 0) begin
				rx_bus.valid   <= 1'b1;
				rx_bus.rx_byte <= pending_bytes.pop_front();
				rx_gap         <= (rx_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
			end else begin
				rx_bus.valid <= 1'b0;
			end
		end
	end

	// Result sink back-pressure.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_stall != 0) begin
				res_bus.ready <= 1'b0;
				res_stall     <= res_stall - 1;
			end else begin
				res_bus.ready <= 1'b1;
				if (!res_calm && $urandom_range(0, 3) == 0) res_stall <= pick_gap();
			end
		end
	end

	// Flip between idling and back-to-back stretches on each side.
	always @(negedge clk) begin
		if ($urandom_range(0, 249) == 0) rx_calm <= !rx_calm;
		if ($urandom_range(0, 249) == 0) res_calm <= !res_calm;
	end

	// ------------------------------------------------------------------
	// Monitor: checks result requests against the oldest owed result and
	// feeds accepted byte requests to the shadow parser.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				if (line_results_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: line result with nothing expected (length %0d)",
							$time, res_bus.line_length);
				end else begin
					got_want = line_results_q.pop_front();
					check_field("line_valid", got_want.line_valid, res_bus.line_valid);
					check_field("satellites", got_want.satellites, res_bus.satellites);
					check_field("is_gga", got_want.is_gga, res_bus.is_gga);
					check_field("line_length", got_want.line_length, res_bus.line_length);
					check_field("valid_count", got_want.valid_count, res_bus.valid_count);
					check_field("byte_count", got_want.byte_count, res_bus.byte_count);
					check_field("fix_seen", got_want.fix_seen, res_bus.fix_seen);
				end
			end
			if (rx_bus.valid && rx_bus.ready) predict_byte(rx_bus.rx_byte);
		end
		rx_taken <= arst_n && rx_bus.valid && rx_bus.ready;
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_MAX_LEN;
		cfg_data       = '0;
		rx_bus.valid   = 1'b0;
		rx_bus.rx_byte = '0;
		res_bus.ready  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: a good GGA sentence, satellites in field 7.
		push_text($sformatf("$%s*%02X", "GPGGA,1,2,3,4,5,6,09,", xor_of("GPGGA,1,2,3,4,5,6,09,")));
		push_byte(CR);
		push_byte(LF);
		wait_quiet();

		// Directed corner cases with the shortest line limit and no minimum.
		apply_setting(10'd16, 8'd0, 4'd1);
		push_line("$j*6a", CR);          // lowercase checksum
		push_line("$A*41", LF);          // uppercase checksum
		push_line("$*", CR);             // no digits -> sum 0
		push_line("$a*6g", CR);          // non-hex stops the checksum
		push_line("$*000", LF);          // third digit ignored
		push_line("$GGA,7,*76", CR);     // valid with satellites: sets fix
		push_line("GGA,-3,", LF);        // sign ends the number
		push_line("*", CR);              // star at the very first position
		push_byte(CR);                   // blank line
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h7F);
		push_byte(8'h1F);
		push_text("xxxxxxxxxxxxxxxxx");  // one past the limit: line dropped
		push_byte(CR);
		push_line("GGA,300,", LF);       // count wraps modulo 256
		push_line("$GGA,12,,,,,*00", CR);
		wait_quiet();

		// Random phases across the register ranges, each drained at the end.
		apply_setting(10'd256, 8'd10, 4'd7);
		random_lines(180);
		wait_quiet();

		apply_setting(10'd1023, 8'd255, 4'd15);
		push_byte("$");
		push_filler(299);                // long line that clears the largest minimum
		push_byte(CR);
		random_lines(150);
		wait_quiet();

		apply_setting(10'd80, 8'd0, 4'd0);
		push_line("12,GGA", CR);         // field zero runs from line start
		random_lines(160);
		wait_quiet();

		apply_setting(10'd16, 8'd255, 4'd1);
		random_lines(100);
		wait_quiet();

		apply_setting(10'd120, 8'd20, 4'd7);
		random_lines(180);
		wait_quiet();

		repeat (10) @(posedge clk);
		if (line_results_q.size() != 0) begin
			mismatch_cnt++;
			$display("%0d expected line results never arrived", line_results_q.size());
		end
		if (mismatch_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
